/* rtl/pixel_format_convert_rotate_defines.svh */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERT_ROTATE_DEFINES_SVH
`define PIXEL_FORMAT_CONVERT_ROTATE_DEFINES_SVH

// Property checked only while out of reset.
`define PFCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define PFCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/pfcr_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: package
// Shared widths, register and format codes, queue item type and colour
// expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcr_pkg;

  localparam int unsigned DimW  = 10;  // column and row counters
  localparam int unsigned CfgW  = 11;  // frame dimension registers
  localparam int unsigned AddrW = 20;
  localparam int unsigned PixW  = 32;
  localparam int unsigned ProdW = DimW + CfgW;

  localparam logic [CfgW-1:0] MaxDimension = 11'd1024;

  // register indexes
  localparam logic [1:0] RegPixelFormat = 2'd0;
  localparam logic [1:0] RegRotation    = 2'd1;
  localparam logic [1:0] RegFrameWidth  = 2'd2;
  localparam logic [1:0] RegFrameHeight = 2'd3;

  // source pixel encodings
  localparam logic [1:0] FmtRgb1555  = 2'd0;
  localparam logic [1:0] FmtXrgb8888 = 2'd1;
  localparam logic [1:0] FmtRgb565   = 2'd2;

  // quarter turns
  localparam logic [1:0] Rot0   = 2'd0;
  localparam logic [1:0] Rot90  = 2'd1;
  localparam logic [1:0] Rot180 = 2'd2;
  localparam logic [1:0] Rot270 = 2'd3;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Classified item: address = mul_a * mul_b + add_c
  typedef struct packed {
    logic [DimW-1:0] mul_a;
    logic [CfgW-1:0] mul_b;
    logic [DimW-1:0] add_c;
    logic            last;
    logic [1:0]      fmt;
    logic [PixW-1:0] pixel;
  } item_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  function automatic logic [PixW-1:0] convert(input logic [1:0] fmt,
                                              input logic [PixW-1:0] px);
    unique case (fmt)
      FmtRgb1555: convert = {AlphaOpaque, widen5(px[14:10]), widen5(px[9:5]),
                             widen5(px[4:0])};
      FmtRgb565:  convert = {AlphaOpaque, widen5(px[15:11]), widen6(px[10:5]),
                             widen5(px[4:0])};
      default:    convert = {AlphaOpaque, px[23:0]};
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/pfcr_queue.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: item queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcr_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire pfcr_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output pfcr_pkg::item_t      item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pfcr_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/pfcr_front.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: front part
// Track source position and reduce each pixel to multiply-add operands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcr_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [pfcr_pkg::PixW-1:0] src_pixel_i,
  input  wire logic [1:0]                fmt_i,
  input  wire logic [1:0]                rot_i,
  input  wire logic [pfcr_pkg::CfgW-1:0] width_i,
  input  wire logic [pfcr_pkg::CfgW-1:0] height_i,
  output pfcr_pkg::item_t                item_o
);

  localparam int unsigned DimW = pfcr_pkg::DimW;
  localparam int unsigned CfgW = pfcr_pkg::CfgW;

  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic [CfgW-1:0] w, h, col_inc, row_inc, col_rev, row_rev;
  logic [DimW-1:0] x, y;
  logic            col_end, row_end;

  // Zero reads as one, oversize saturates.
  assign w = (width_i == '0) ? CfgW'(1) :
             (width_i > pfcr_pkg::MaxDimension) ? pfcr_pkg::MaxDimension : width_i;
  assign h = (height_i == '0) ? CfgW'(1) :
             (height_i > pfcr_pkg::MaxDimension) ? pfcr_pkg::MaxDimension : height_i;

  // Restart a counter left out of bounds by a shrunk frame.
  assign x = ({1'b0, col_q} >= w) ? '0 : col_q;
  assign y = ({1'b0, row_q} >= h) ? '0 : row_q;

  assign col_inc = {1'b0, x} + 1'b1;
  assign row_inc = {1'b0, y} + 1'b1;
  assign col_end = (col_inc >= w);
  assign row_end = (row_inc >= h);
  assign col_rev = w - col_inc;
  assign row_rev = h - row_inc;

  always_comb begin
    item_o.last  = col_end && row_end;
    item_o.fmt   = fmt_i;
    item_o.pixel = src_pixel_i;
    unique case (rot_i)
      pfcr_pkg::Rot0: begin
        item_o.mul_a = y;
        item_o.mul_b = w;
        item_o.add_c = x;
      end
      pfcr_pkg::Rot90: begin
        item_o.mul_a = col_rev[DimW-1:0];
        item_o.mul_b = h;
        item_o.add_c = y;
      end
      pfcr_pkg::Rot180: begin
        item_o.mul_a = row_rev[DimW-1:0];
        item_o.mul_b = w;
        item_o.add_c = col_rev[DimW-1:0];
      end
      pfcr_pkg::Rot270: begin
        item_o.mul_a = x;
        item_o.mul_b = h;
        item_o.add_c = row_rev[DimW-1:0];
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_inc[DimW-1:0];
      end else begin
        col_d = col_inc[DimW-1:0];
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/pfcr_back.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: back part
// Multiply, add and expand colour over two stages; the last is the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcr_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire pfcr_pkg::item_t            q_item_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [pfcr_pkg::AddrW-1:0]      dest_address_o,
  output logic [pfcr_pkg::PixW-1:0]       argb_color_o,
  output logic                            frame_last_o
);

  localparam int unsigned ProdW = pfcr_pkg::ProdW;
  localparam int unsigned AddrW = pfcr_pkg::AddrW;
  localparam int unsigned PixW  = pfcr_pkg::PixW;
  localparam int unsigned DimW  = pfcr_pkg::DimW;

  logic             s1_vld_q, out_vld_q;
  logic [ProdW-1:0] prod_q, sum;
  logic [DimW-1:0]  add_c_q;
  logic [PixW-1:0]  color_q, argb_q;
  logic             last_q, flast_q;
  logic [AddrW-1:0] addr_q;
  logic             adv_out, take_s1;

  assign adv_out = s1_vld_q && (!out_vld_q || pop_i);
  assign take_s1 = !s1_vld_q || adv_out;
  assign q_pop_o = take_s1 && !q_empty_i;
  assign sum     = prod_q + ProdW'(add_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take_s1) begin
        s1_vld_q <= !q_empty_i;
      end
      if (adv_out) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_q  <= ProdW'(q_item_i.mul_a) * ProdW'(q_item_i.mul_b);
      add_c_q <= q_item_i.add_c;
      color_q <= pfcr_pkg::convert(q_item_i.fmt, q_item_i.pixel);
      last_q  <= q_item_i.last;
    end
    if (adv_out) begin
      addr_q  <= sum[AddrW-1:0];
      argb_q  <= color_q;
      flast_q <= last_q;
    end
  end

  assign empty_o        = !out_vld_q;
  assign dest_address_o = addr_q;
  assign argb_color_o   = argb_q;
  assign frame_last_o   = flast_q;

endmodule

`default_nettype wire

/* rtl/pixel_format_convert_rotate.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate
// Expand 0RGB1555 / RGB565 / XRGB8888 source pixels to ARGB8888 and give the
// rotated frame-buffer index of each one.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  pixel in  | push / full        | src_pixel_i
//  result    | empty / pop        | dest_address_o, argb_color_o,
//            |                    | frame_last_o
//  config    | cfg_we_i           | cfg_index_i, cfg_data_i
//
//  One pixel per clock sustained while results are popped; each passes the
//  queue, the multiply stage and the output register before it shows on the
//  result ports, on a single multiply-add path for the address.
//  Reset clears counters and control flags, presets config; no clearing pass.
//  A stalled result holds; the queue and multiply stage keep taking pixels
//  until QueueDepth + 2 are in flight, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_convert_rotate #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // pixel in
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [pfcr_pkg::PixW-1:0]  src_pixel_i,
  // result out
  output logic                            empty,
  input  wire logic                       pop,
  output logic [pfcr_pkg::AddrW-1:0]      dest_address_o,
  output logic [pfcr_pkg::PixW-1:0]       argb_color_o,
  output logic                            frame_last_o,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [pfcr_pkg::CfgW-1:0]  cfg_data_i
);

  localparam int unsigned CfgW = pfcr_pkg::CfgW;

  // Configuration registers
  logic [1:0]      fmt_q, rot_q;
  logic [CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= pfcr_pkg::FmtRgb1555;
      rot_q    <= pfcr_pkg::Rot0;
      width_q  <= CfgW'(1);
      height_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfcr_pkg::RegPixelFormat: fmt_q    <= cfg_data_i[1:0];
        pfcr_pkg::RegRotation:    rot_q    <= cfg_data_i[1:0];
        pfcr_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        pfcr_pkg::RegFrameHeight: height_q <= cfg_data_i;
      endcase
    end
  end

  // Front: take the transfer, advance position, classify into operands
  logic            in_xfer;
  pfcr_pkg::item_t front_item, q_item;
  logic            q_empty, q_pop;

  assign in_xfer = push && !full;

  pfcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .src_pixel_i (src_pixel_i),
    .fmt_i       (fmt_q),
    .rot_i       (rot_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .item_o      (front_item)
  );

  // Queue decouples the two halves so either may stall alone
  pfcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  // Back: multiply, add, expand colour, hold the result
  pfcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .dest_address_o (dest_address_o),
    .argb_color_o   (argb_color_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

`default_nettype wire

/* rtl/pfcr_checker.sv */
// ----------------------------------------------------------------------------
// Pixel format convert and rotate: port checker
// Watch the handshakes and the occupancy seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_format_convert_rotate_defines.svh"

module pfcr_checker #(
  parameter int unsigned QueueDepth = 2
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      push,
  input wire logic                      full,
  input wire logic                      empty,
  input wire logic                      pop,
  input wire logic [pfcr_pkg::AddrW-1:0] dest_address_o,
  input wire logic [pfcr_pkg::PixW-1:0]  argb_color_o,
  input wire logic                      frame_last_o
);

  localparam int unsigned Capacity = QueueDepth + 2;
  localparam int unsigned OccW     = $clog2(Capacity + 1) + 1;
  localparam logic [OccW-1:0] CapOcc = OccW'(Capacity);

  logic [OccW-1:0] occ_q;
  logic            in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // Count pixels taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      occ_q <= occ_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  `PFCR_ASSERT_ALWAYS(a_empty_out_of_reset, clk_i, $rose(rst_ni) |-> empty, "result shown straight after reset")
  `PFCR_ASSERT(a_no_invented_result, clk_i, rst_ni, !empty |-> (occ_q != '0), "result without a pending pixel")
  `PFCR_ASSERT(a_occupancy_bound, clk_i, rst_ni, occ_q <= CapOcc, "more pixels in flight than the block holds")
  `PFCR_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(dest_address_o) && $stable(argb_color_o) && $stable(frame_last_o)), "stalled result changed")

endmodule

bind pixel_format_convert_rotate pfcr_checker #(
  .QueueDepth (QueueDepth)
) u_pfcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .dest_address_o (dest_address_o),
  .argb_color_o   (argb_color_o),
  .frame_last_o   (frame_last_o)
);

`default_nettype wire
